/* sv/stun_response_address_parser_assert.svh */
// Assertion macros shared by the STUN response parser.
`ifndef STUN_RESPONSE_ADDRESS_PARSER_ASSERT_SVH
`define STUN_RESPONSE_ADDRESS_PARSER_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define STUN_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("stun parser assertion failed");

// Next-cycle implication.
`define STUN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("stun parser assertion failed");

`endif

/* sv/stun_pkg.sv */
// Types and constants of the STUN response address parser.
package stun_pkg;

    localparam logic [31:0] COOKIE          = 32'h2112_A442;
    localparam logic [15:0] KIND_MAPPED     = 16'h0001;
    localparam logic [15:0] KIND_XOR_MAPPED = 16'h0020;
    localparam logic [7:0]  FAMILY_V4       = 8'h01;
    localparam logic [7:0]  FAMILY_V6       = 8'h02;

    localparam int          CNT_W     = 17;
    localparam logic [16:0] CNT_MAX   = 17'h1_FFFF;
    localparam logic [16:0] HDR_BYTES = 17'd20;

    localparam logic [1:0] FAM_NONE = 2'd0;
    localparam logic [1:0] FAM_V4   = 2'd1;
    localparam logic [1:0] FAM_V6   = 2'd2;

    typedef enum logic [1:0] {
        HERR_NONE   = 2'd0,
        HERR_TYPE   = 2'd1,
        HERR_COOKIE = 2'd2
    } t_herr;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_TYPE_BITS = 3'd2,
        ST_COOKIE    = 3'd3,
        ST_LENGTH    = 3'd4,
        ST_TRUNCATED = 3'd5
    } t_status;

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] up;
        logic [15:0] port;
        logic [1:0]  family;
        logic        found;
    } t_kept;

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] up;
        logic [15:0] port;
        logic [1:0]  family;
        logic        found;
        logic [2:0]  status;
    } t_result;

    // Header tracker view: current counter and transaction ID, next-state values.
    typedef struct packed {
        logic [CNT_W-1:0] counter;
        logic             in_attr;
        logic [CNT_W-1:0] n_counter;
        t_herr            n_error;
        logic [15:0]      n_decl_len;
        logic [31:0]      txn_upper;
        logic [63:0]      txn_lower;
    } t_hdr_info;

    typedef struct packed {
        logic [CNT_W-1:0] n_position;
        t_kept            n_kept;
    } t_attr_info;

endpackage

/* sv/stun_response_address_parser.sv */
// STUN response address parser top level.
// The slave stream carries one datagram byte per word in s_tdata, with s_tlast set on
// the final byte. Each accepted word updates the header tracker and the attribute
// walker in the same cycle, so a word can be taken on every clock while s_tready is high.
// On the word with s_tlast the block writes one result word to the master stream:
// status, found flag, family, port and the 128-bit address (all zero on error).
// The result is registered before it appears on m_tvalid and is
// held until m_tready takes it. Bytes that are not last never produce a word.
// Throughput is one byte per cycle while s_tready is high; the parse logic
// between the parser state registers is combinational.
// When the receiver stalls, a second result is parked in a skid entry, and
// s_tready drops only while that skid entry is occupied.
// A synchronous reset (i_rst_n low) empties the output and clears all parser
// state; the block also clears its parser state after every last byte, so each
// datagram starts from a clean header.
module stun_response_address_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // [7:0] byte_value
    input  logic          s_tlast,   // last_byte
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [151:0]  m_tdata    // status, address_found, address_family,
                                     // mapped_port, address_upper, address_lower, pad
);
    import stun_pkg::*;

`include "stun_response_address_parser_assert.svh"

    logic       w_accept;
    t_hdr_info  w_hdr;
    t_attr_info w_attr;
    t_result    w_result;
    t_result    w_out_result;
    t_status    w_status;

    assign w_accept = s_tvalid && s_tready;

    stun_hdr u_hdr (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (s_tdata),
        .i_last   (s_tlast),
        .o_hdr    (w_hdr)
    );

    stun_attr u_attr (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (s_tdata),
        .i_last   (s_tlast),
        .i_hdr    (w_hdr),
        .o_attr   (w_attr)
    );

    // Errors are checked in priority order on the state after the last byte.
    always_comb begin
        if (w_hdr.n_counter < HDR_BYTES) begin
            w_status = ST_SHORT;
        end else if (w_hdr.n_error == HERR_TYPE) begin
            w_status = ST_TYPE_BITS;
        end else if (w_hdr.n_error == HERR_COOKIE) begin
            w_status = ST_COOKIE;
        end else if ({1'b0, w_hdr.n_decl_len} != (w_hdr.n_counter - HDR_BYTES)) begin
            w_status = ST_LENGTH;
        end else if (w_attr.n_position != '0) begin
            w_status = ST_TRUNCATED;
        end else begin
            w_status = ST_OK;
        end
    end

    always_comb begin
        w_result        = '0;
        w_result.status = w_status;
        if (w_status == ST_OK) begin
            w_result.found  = w_attr.n_kept.found;
            w_result.family = w_attr.n_kept.family;
            w_result.port   = w_attr.n_kept.port;
            w_result.up     = w_attr.n_kept.up;
            w_result.lo     = w_attr.n_kept.lo;
        end
    end

    stun_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_accept && s_tlast),
        .i_result     (w_result),
        .o_ready      (s_tready),
        .o_valid      (m_tvalid),
        .o_result     (w_out_result),
        .i_take_ready (m_tready)
    );

    assign m_tdata = {2'b00, w_out_result};

    `STUN_ASSERT_IMPL(a_stall_has_result, i_clk, i_rst_n, !s_tready, m_tvalid)
    `STUN_ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, w_accept && s_tlast, m_tvalid)
    `STUN_ASSERT_NEXT(a_last_clears_count, i_clk, i_rst_n, w_accept && s_tlast,
        w_hdr.counter == '0)
    `STUN_ASSERT_IMPL(a_error_no_address, i_clk, i_rst_n,
        m_tvalid && (w_out_result.status != ST_OK),
        !w_out_result.found && (w_out_result.family == FAM_NONE))

endmodule

/* sv/stun_hdr.sv */
// Header tracker: byte counter, type and cookie checks, length and transaction ID.
module stun_hdr (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_byte,
    input  logic                  i_last,
    output stun_pkg::t_hdr_info   o_hdr
);
    import stun_pkg::*;

    logic [CNT_W-1:0] r_counter, n_counter;
    t_herr            r_error, n_error;
    logic [15:0]      r_decl_len, n_decl_len;
    logic [31:0]      r_txn_upper, n_txn_upper;
    logic [63:0]      r_txn_lower, n_txn_lower;
    logic [7:0]       w_cookie_byte;

    always_comb begin
        case (r_counter[1:0])
            2'd0:    w_cookie_byte = COOKIE[31:24];
            2'd1:    w_cookie_byte = COOKIE[23:16];
            2'd2:    w_cookie_byte = COOKIE[15:8];
            default: w_cookie_byte = COOKIE[7:0];
        endcase
    end

    always_comb begin
        n_error     = r_error;
        n_decl_len  = r_decl_len;
        n_txn_upper = r_txn_upper;
        n_txn_lower = r_txn_lower;
        n_counter   = (r_counter != CNT_MAX) ? r_counter + 1'b1 : r_counter;
        if (r_counter == 17'd0) begin
            if (i_byte[7:6] != 2'b00 && r_error == HERR_NONE) begin
                n_error = HERR_TYPE;
            end
        end else if (r_counter == 17'd2 || r_counter == 17'd3) begin
            n_decl_len = {r_decl_len[7:0], i_byte};
        end else if (r_counter >= 17'd4 && r_counter < 17'd8) begin
            if (i_byte != w_cookie_byte && r_error == HERR_NONE) begin
                n_error = HERR_COOKIE;
            end
        end else if (r_counter >= 17'd8 && r_counter < 17'd12) begin
            n_txn_upper = {r_txn_upper[23:0], i_byte};
        end else if (r_counter >= 17'd12 && r_counter < HDR_BYTES) begin
            n_txn_lower = {r_txn_lower[55:0], i_byte};
        end
    end

    // The last word of a datagram returns everything to the reset state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last)) begin
            r_counter   <= '0;
            r_error     <= HERR_NONE;
            r_decl_len  <= '0;
            r_txn_upper <= '0;
            r_txn_lower <= '0;
        end else if (i_accept) begin
            r_counter   <= n_counter;
            r_error     <= n_error;
            r_decl_len  <= n_decl_len;
            r_txn_upper <= n_txn_upper;
            r_txn_lower <= n_txn_lower;
        end
    end

    assign o_hdr.counter    = r_counter;
    assign o_hdr.in_attr    = (r_counter >= HDR_BYTES);
    assign o_hdr.n_counter  = n_counter;
    assign o_hdr.n_error    = n_error;
    assign o_hdr.n_decl_len = n_decl_len;
    assign o_hdr.txn_upper  = r_txn_upper;
    assign o_hdr.txn_lower  = r_txn_lower;

endmodule

/* sv/stun_attr.sv */
// Attribute walker: TLV position, value capture and mapped address decode.
module stun_attr (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_byte,
    input  logic                  i_last,
    input  stun_pkg::t_hdr_info   i_hdr,
    output stun_pkg::t_attr_info  o_attr
);
    import stun_pkg::*;

    logic [15:0]      r_kind, n_kind;
    logic [15:0]      r_len, n_len;
    logic [CNT_W-1:0] r_pos, n_pos;
    logic [7:0]       r_family, n_family;
    logic [15:0]      r_port, n_port;
    logic [63:0]      r_addr0, n_addr0;
    logic [63:0]      r_addr1, n_addr1;
    t_kept            r_kept, n_kept;
    logic             w_active;

    function automatic t_kept f_decode(input logic [15:0] kind, input logic [7:0] fam,
                                       input logic [15:0] port, input logic [63:0] a0,
                                       input logic [63:0] a1, input logic [31:0] tu,
                                       input logic [63:0] tl, input t_kept prev);
        t_kept k;
        logic  is_xor;
        k      = prev;
        is_xor = (kind == KIND_XOR_MAPPED);
        if (kind == KIND_MAPPED || is_xor) begin
            k.found = 1'b1;
            k.port  = is_xor ? (port ^ COOKIE[31:16]) : port;
            if (fam == FAMILY_V4) begin
                k.family = FAM_V4;
                k.up     = '0;
                k.lo     = {32'd0, a0[63:32] ^ (is_xor ? COOKIE : 32'd0)};
            end else if (fam == FAMILY_V6) begin
                k.family = FAM_V6;
                k.up     = a0 ^ (is_xor ? {COOKIE, tu} : 64'd0);
                k.lo     = a1 ^ (is_xor ? tl : 64'd0);
            end else begin
                // An unknown family throws away whatever was kept before.
                k = '0;
            end
        end
        return k;
    endfunction

    assign w_active = i_accept && i_hdr.in_attr;

    always_comb begin
        logic [CNT_W-1:0] v;
        logic [CNT_W-1:0] pos_inc;
        logic [CNT_W-1:0] len_up;
        logic [CNT_W-1:0] span;
        logic             decode_now;
        n_kind     = r_kind;
        n_len      = r_len;
        n_family   = r_family;
        n_port     = r_port;
        n_addr0    = r_addr0;
        n_addr1    = r_addr1;
        n_kept     = r_kept;
        decode_now = 1'b0;
        v          = r_pos - 17'd4;
        if (r_pos < 17'd4) begin
            if (r_pos < 17'd2) begin
                n_kind = {r_kind[7:0], i_byte};
            end else begin
                n_len = {r_len[7:0], i_byte};
            end
            if (r_pos == 17'd3) begin
                n_family   = '0;
                n_port     = '0;
                n_addr0    = '0;
                n_addr1    = '0;
                decode_now = (n_len == 16'd0);
            end
        end else begin
            // Value bytes past the twentieth are dropped.
            if (v < {1'b0, r_len} && v < 17'd20) begin
                if (v == 17'd1) begin
                    n_family = i_byte;
                end else if (v == 17'd2 || v == 17'd3) begin
                    n_port = {r_port[7:0], i_byte};
                end else begin
                    for (int i = 0; i < 8; i++) begin
                        if (v[4:0] == 5'(11 - i)) begin
                            n_addr0[8*i +: 8] = r_addr0[8*i +: 8] | i_byte;
                        end
                        if (v[4:0] == 5'(19 - i)) begin
                            n_addr1[8*i +: 8] = r_addr1[8*i +: 8] | i_byte;
                        end
                    end
                end
            end
            decode_now = (({1'b0, v} + 18'd1) == {2'b00, r_len});
        end
        if (decode_now) begin
            n_kept = f_decode(n_kind, n_family, n_port, n_addr0, n_addr1,
                              i_hdr.txn_upper, i_hdr.txn_lower, r_kept);
        end
        // Padded attribute span is 4 header bytes plus the length rounded up to 4.
        pos_inc = r_pos + 17'd1;
        len_up  = {1'b0, n_len} + 17'd3;
        span    = {len_up[CNT_W-1:2], 2'b00} + 17'd4;
        n_pos   = (pos_inc >= 17'd4 && pos_inc >= span) ? '0 : pos_inc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last)) begin
            r_kind   <= '0;
            r_len    <= '0;
            r_pos    <= '0;
            r_family <= '0;
            r_port   <= '0;
            r_addr0  <= '0;
            r_addr1  <= '0;
            r_kept   <= '0;
        end else if (w_active) begin
            r_kind   <= n_kind;
            r_len    <= n_len;
            r_pos    <= n_pos;
            r_family <= n_family;
            r_port   <= n_port;
            r_addr0  <= n_addr0;
            r_addr1  <= n_addr1;
            r_kept   <= n_kept;
        end
    end

    assign o_attr.n_position = w_active ? n_pos : r_pos;
    assign o_attr.n_kept     = w_active ? n_kept : r_kept;

endmodule

/* sv/stun_out.sv */
// Result output register with a skid entry behind it.
module stun_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  stun_pkg::t_result  i_result,
    output logic               o_ready,
    output logic               o_valid,
    output stun_pkg::t_result  o_result,
    input  logic               i_take_ready
);
    import stun_pkg::*;

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (r_out_valid && i_take_ready) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
        // A push only happens while the skid entry is free.
        if (i_push) begin
            if (!n_out_valid) begin
                n_out_valid = 1'b1;
                n_out       = i_result;
            end else begin
                n_skid_valid = 1'b1;
                n_skid       = i_result;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_ready  = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

/* tb/stun_response_address_parser_tb.sv */
// Self-checking testbench for the STUN response address parser.
`timescale 1ns / 1ps

module stun_response_address_parser_tb;

    import stun_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    // Tracks the parser state from the accepted bytes and holds the results it predicts.
    class stun_parse_scoreboard;
        bit [CNT_W-1:0] byte_cnt;
        t_herr          hdr_err;
        bit [15:0]      decl_len;
        bit [31:0]      txn_up;
        bit [63:0]      txn_lo;
        bit [15:0]      attr_kind;
        bit [15:0]      attr_len;
        bit [CNT_W-1:0] attr_pos;
        bit [7:0]       val_family;
        bit [15:0]      val_port;
        bit [63:0]      val_addr_up;
        bit [63:0]      val_addr_lo;
        t_kept          kept;
        t_result        expected_q[$];
        int             mismatches;
        int             error_count;

        function new();
            mismatches = 0;
            error_count = 0;
            clear_state();
        endfunction

        function void clear_state();
            byte_cnt = '0;
            hdr_err = HERR_NONE;
            decl_len = '0;
            txn_up = '0;
            txn_lo = '0;
            attr_kind = '0;
            attr_len = '0;
            attr_pos = '0;
            val_family = '0;
            val_port = '0;
            val_addr_up = '0;
            val_addr_lo = '0;
            kept = '0;
        endfunction

        function void decode_value();
            bit        is_xor;
            bit [15:0] port;
            bit [63:0] up;
            bit [63:0] lo;
            is_xor = (attr_kind == KIND_XOR_MAPPED);
            port = val_port;
            up = '0;
            lo = '0;
            if (attr_kind != KIND_MAPPED && !is_xor)
                return;
            if (is_xor)
                port ^= COOKIE[31:16];
            if (val_family == FAMILY_V4) begin
                lo = {32'd0, val_addr_up[63:32]};
                if (is_xor)
                    lo ^= {32'd0, COOKIE};
            end else if (val_family == FAMILY_V6) begin
                up = val_addr_up;
                lo = val_addr_lo;
                if (is_xor) begin
                    up ^= {COOKIE, txn_up};
                    lo ^= txn_lo;
                end
            end else begin
                // An unknown family wipes whatever address was kept so far.
                kept = '0;
                return;
            end
            kept.found = 1'b1;
            kept.family = val_family[1:0];
            kept.port = port;
            kept.up = up;
            kept.lo = lo;
        endfunction

        function void header_byte(int unsigned idx, bit [7:0] b);
            if (idx == 0) begin
                if (b[7:6] != 2'b00 && hdr_err == HERR_NONE)
                    hdr_err = HERR_TYPE;
            end else if (idx == 2 || idx == 3) begin
                decl_len = {decl_len[7:0], b};
            end else if (idx >= 4 && idx < 8) begin
                if (b != COOKIE[8*(7-idx) +: 8] && hdr_err == HERR_NONE)
                    hdr_err = HERR_COOKIE;
            end else if (idx >= 8 && idx < 12) begin
                txn_up = {txn_up[23:0], b};
            end else if (idx >= 12 && idx < 20) begin
                txn_lo = {txn_lo[55:0], b};
            end
        endfunction

        function void attribute_byte(bit [7:0] b);
            int unsigned pos;
            int unsigned v;
            int unsigned span;
            pos = attr_pos;
            if (pos < 4) begin
                if (pos < 2)
                    attr_kind = {attr_kind[7:0], b};
                else
                    attr_len = {attr_len[7:0], b};
                if (pos == 3) begin
                    val_family = '0;
                    val_port = '0;
                    val_addr_up = '0;
                    val_addr_lo = '0;
                    if (attr_len == 0)
                        decode_value();
                end
            end else begin
                v = pos - 4;
                if (v < attr_len && v < 20) begin
                    if (v == 1)
                        val_family = b;
                    else if (v == 2 || v == 3)
                        val_port = {val_port[7:0], b};
                    else if (v >= 4 && v < 12)
                        val_addr_up |= 64'(b) << (8 * (11 - v));
                    else if (v >= 12)
                        val_addr_lo |= 64'(b) << (8 * (19 - v));
                end
                if (v + 1 == attr_len)
                    decode_value();
            end
            pos++;
            // Attribute span is the 4-byte header plus the value padded to 4 bytes.
            span = 4 + ((int'(attr_len) + 3) & ~32'd3);
            if (pos >= 4 && pos >= span)
                pos = 0;
            attr_pos = pos[CNT_W-1:0];
        endfunction

        function void note_byte(bit [7:0] b, bit is_last);
            t_result exp;
            t_status st;
            if (byte_cnt < HDR_BYTES)
                header_byte(byte_cnt, b);
            else
                attribute_byte(b);
            if (byte_cnt < CNT_MAX)
                byte_cnt++;
            if (!is_last)
                return;
            if (byte_cnt < HDR_BYTES)
                st = ST_SHORT;
            else if (hdr_err == HERR_TYPE)
                st = ST_TYPE_BITS;
            else if (hdr_err == HERR_COOKIE)
                st = ST_COOKIE;
            else if ({1'b0, decl_len} != byte_cnt - HDR_BYTES)
                st = ST_LENGTH;
            else if (attr_pos != 0)
                st = ST_TRUNCATED;
            else
                st = ST_OK;
            exp = '0;
            exp.status = st;
            if (st == ST_OK) begin
                exp.found = kept.found;
                exp.family = kept.family;
                exp.port = kept.port;
                exp.up = kept.up;
                exp.lo = kept.lo;
            end
            expected_q.push_back(exp);
            clear_state();
        endfunction

        function void check_result(t_result got);
            t_result exp;
            if (expected_q.size() == 0) begin
                error_count++;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: %h", got);
                return;
            end
            exp = expected_q.pop_front();
            if (got.status !== exp.status || got.found !== exp.found ||
                got.family !== exp.family || got.port !== exp.port ||
                got.up !== exp.up || got.lo !== exp.lo) begin
                error_count++;
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result mismatch: status exp %0d got %0d, found exp %0d got %0d",
                             exp.status, got.status, exp.found, got.found);
                    $display("  family exp %0d got %0d, port exp %h got %h",
                             exp.family, got.family, exp.port, got.port);
                    $display("  upper exp %h got %h", exp.up, got.up);
                    $display("  lower exp %h got %h", exp.lo, got.lo);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void close_out();
            if (expected_q.size() != 0) begin
                error_count += expected_q.size();
                $display("%0d expected result words never arrived", expected_q.size());
            end
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [151:0] m_tdata;

    stun_parse_scoreboard sb = new();

    logic [7:0] dgram_q[$];        // datagram under construction
    logic [8:0] byte_stream_q[$];  // {last, byte} for every word to send

    stun_response_address_parser DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic void push_datagram();
        for (int i = 0; i < dgram_q.size(); i++)
            byte_stream_q.push_back({i == dgram_q.size() - 1, dgram_q[i]});
    endfunction

    function automatic void push_header(bit type_bits, bit bad_cookie);
        int bad_idx;
        bad_idx = $urandom_range(3);
        dgram_q.delete();
        if (type_bits)
            dgram_q.push_back({2'($urandom_range(1, 3)), 6'($urandom)});
        else
            dgram_q.push_back({2'b00, 6'($urandom)});
        dgram_q.push_back(8'($urandom));
        dgram_q.push_back(8'h00);
        dgram_q.push_back(8'h00);
        for (int i = 0; i < 4; i++) begin
            if (bad_cookie && i == bad_idx)
                dgram_q.push_back(COOKIE[8*(3-i) +: 8] ^ 8'($urandom_range(1, 255)));
            else
                dgram_q.push_back(COOKIE[8*(3-i) +: 8]);
        end
        for (int i = 0; i < 12; i++)
            dgram_q.push_back(8'($urandom));
    endfunction

    function automatic void add_attribute();
        int         r;
        int         len;
        logic [15:0] kind;
        logic [7:0]  fam;
        r = $urandom_range(99);
        if (r < 40)
            kind = KIND_XOR_MAPPED;
        else if (r < 70)
            kind = KIND_MAPPED;
        else if (r < 90)
            kind = 16'($urandom);
        else
            kind = KIND_XOR_MAPPED ^ 16'($urandom_range(1, 3));
        r = $urandom_range(99);
        fam = (r < 45) ? FAMILY_V4 : (r < 90) ? FAMILY_V6 : 8'($urandom);
        if ($urandom_range(99) < 15)
            len = $urandom_range(0, 28);
        else
            len = (fam == FAMILY_V6) ? 20 : 8;
        dgram_q.push_back(kind[15:8]);
        dgram_q.push_back(kind[7:0]);
        dgram_q.push_back(8'(len >> 8));
        dgram_q.push_back(8'(len));
        for (int v = 0; v < len; v++)
            dgram_q.push_back((v == 1) ? fam : 8'($urandom));
        // Padding bytes carry random content; the parser must skip them.
        while (dgram_q.size() % 4 != 0)
            dgram_q.push_back(8'($urandom));
    endfunction

    function automatic void build_random_response();
        int          scenario;
        int          n_attr;
        int          attr_size;
        int          start;
        int          delta;
        int unsigned body;
        logic [15:0] decl;
        scenario = $urandom_range(99);
        if (scenario >= 70 && scenario < 75) begin
            dgram_q.delete();
            repeat ($urandom_range(1, 19))
                dgram_q.push_back(8'($urandom));
            push_datagram();
            return;
        end
        push_header(scenario >= 75 && scenario < 80,
                    (scenario >= 80 && scenario < 85) ||
                    (scenario >= 75 && scenario < 80 && $urandom_range(1) == 1));
        n_attr = $urandom_range(0, 4);
        attr_size = 0;
        for (int i = 0; i < n_attr; i++) begin
            start = dgram_q.size();
            add_attribute();
            attr_size = dgram_q.size() - start;
        end
        if (scenario >= 92) begin
            // End the datagram inside an attribute while keeping the length consistent.
            if (attr_size > 0 && $urandom_range(1) == 1) begin
                repeat ($urandom_range(1, attr_size - 1))
                    void'(dgram_q.pop_back());
            end else begin
                repeat ($urandom_range(1, 3))
                    dgram_q.push_back(8'($urandom));
            end
        end
        body = dgram_q.size() - 20;
        decl = body[15:0];
        if (scenario >= 85 && scenario < 92) begin
            delta = $urandom_range(1, 8);
            if ($urandom_range(1) == 1)
                decl = decl + 16'(delta);
            else
                decl = decl - 16'(delta);
        end
        dgram_q[2] = decl[15:8];
        dgram_q[3] = decl[7:0];
        push_datagram();
    endfunction

    task automatic drive_bytes();
        int idx;
        bit idle;
        idx = 0;
        while (idx < byte_stream_q.size() || s_tvalid) begin
            @(posedge i_clk);
            if (s_tvalid && s_tready)
                idx++;
            if (!s_tvalid || s_tready) begin
                idle = !(idx >= 200 && idx < 700) && ($urandom_range(99) < 34);
                if (idx < byte_stream_q.size() && !idle) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= byte_stream_q[idx][7:0];
                    s_tlast <= byte_stream_q[idx][8];
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && s_tready)
                sb.note_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                sb.check_result(t_result'(m_tdata[149:0]));
        end
    end

    // Receiver: random stalls, a calm window, and one long hold-off to back up the input.
    initial begin
        int got = 0;
        int cyc = 0;
        int stall_left = 0;
        bit stalled = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (m_tvalid && m_tready)
                got++;
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!stalled && got >= 5) begin
                stalled = 1'b1;
                stall_left = 400;
                m_tready <= 1'b0;
            end else if (cyc >= 3000 && cyc < 4500) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= 34);
            end
        end
    end

    initial begin
        int quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        int random_bytes = 0;
        int mark;
        i_rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= 8'h00;
        s_tlast <= 1'b0;

        // A lone all-ones byte is a short datagram; then a bare header with no attributes.
        byte_stream_q.push_back({1'b1, 8'hFF});
        dgram_q.delete();
        dgram_q.push_back(8'h01);
        dgram_q.push_back(8'h01);
        dgram_q.push_back(8'h00);
        dgram_q.push_back(8'h00);
        for (int i = 0; i < 4; i++)
            dgram_q.push_back(COOKIE[8*(3-i) +: 8]);
        for (int i = 0; i < 12; i++)
            dgram_q.push_back((i % 2 == 0) ? 8'hFF : 8'h00);
        push_datagram();

        while (random_bytes < 1900) begin
            mark = byte_stream_q.size();
            build_random_response();
            random_bytes += byte_stream_q.size() - mark;
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        drive_bytes();
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        sb.close_out();
        if (sb.error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
